### hdl/ptt_pkg.sv
// Shared constants for the point-in-triangle test.
// No dependencies; ptt_cfg_regs and the top level import this package.
package ptt_pkg;

  // Configuration register index: wide enough to address past the last register
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 2'd2;

endpackage

### hdl/ptt_cfg_regs.sv
// Vertex configuration registers A, B and C, written through the plain write port.
// Depends on ptt_pkg for the register indexes.
module ptt_cfg_regs #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [3*COORD_WIDTH-1:0]          cfg_data,
  output logic [3*COORD_WIDTH-1:0]          vertex_a,
  output logic [3*COORD_WIDTH-1:0]          vertex_b,
  output logic [3*COORD_WIDTH-1:0]          vertex_c
);
  import ptt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a <= '0;
      vertex_b <= '0;
      vertex_c <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_A: vertex_a <= cfg_data;
        REG_VERTEX_B: vertex_b <= cfg_data;
        REG_VERTEX_C: vertex_c <= cfg_data;
        default: ;  // drop writes past the last register
      endcase
    end
  end

endmodule

### hdl/ptt_dot_front.sv
// Front of the pipeline: edge vectors (stage 1) and the five dot products (stage 2).
// Uses no package items; vertex registers come from ptt_cfg_regs.
module ptt_dot_front #(
  parameter int COORD_WIDTH = 16,
  parameter int DW          = 2 * (COORD_WIDTH + 1) + 2
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [3*COORD_WIDTH-1:0]         vertex_a,
  input  logic [3*COORD_WIDTH-1:0]         vertex_b,
  input  logic [3*COORD_WIDTH-1:0]         vertex_c,
  input  logic signed [COORD_WIDTH-1:0]    point_x,
  input  logic signed [COORD_WIDTH-1:0]    point_y,
  input  logic signed [COORD_WIDTH-1:0]    point_z,
  output logic signed [DW-1:0]             d00,
  output logic signed [DW-1:0]             d01,
  output logic signed [DW-1:0]             d02,
  output logic signed [DW-1:0]             d11,
  output logic signed [DW-1:0]             d12
);
  localparam int W  = COORD_WIDTH;
  localparam int EW = W + 1;
  localparam int MW = 2 * EW;

  logic [W-1:0]            pt [3];
  logic signed [EW-1:0]    e0_next [3];
  logic signed [EW-1:0]    e1_next [3];
  logic signed [EW-1:0]    e2_next [3];
  logic signed [EW-1:0]    e0 [3];
  logic signed [EW-1:0]    e1 [3];
  logic signed [EW-1:0]    e2 [3];
  logic signed [MW-1:0]    m00 [3];
  logic signed [MW-1:0]    m01 [3];
  logic signed [MW-1:0]    m02 [3];
  logic signed [MW-1:0]    m11 [3];
  logic signed [MW-1:0]    m12 [3];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e0_next[i] = $signed({vertex_c[i*W+W-1], vertex_c[i*W +: W]})
                 - $signed({vertex_a[i*W+W-1], vertex_a[i*W +: W]});
      e1_next[i] = $signed({vertex_b[i*W+W-1], vertex_b[i*W +: W]})
                 - $signed({vertex_a[i*W+W-1], vertex_a[i*W +: W]});
      e2_next[i] = $signed({pt[i][W-1], pt[i]})
                 - $signed({vertex_a[i*W+W-1], vertex_a[i*W +: W]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0[i] <= e0_next[i];
        e1[i] <= e1_next[i];
        e2[i] <= e2_next[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m00[i] = MW'(e0[i]) * MW'(e0[i]);
      m01[i] = MW'(e0[i]) * MW'(e1[i]);
      m02[i] = MW'(e0[i]) * MW'(e2[i]);
      m11[i] = MW'(e1[i]) * MW'(e1[i]);
      m12[i] = MW'(e1[i]) * MW'(e2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d00 <= DW'(m00[0]) + DW'(m00[1]) + DW'(m00[2]);
      d01 <= DW'(m01[0]) + DW'(m01[1]) + DW'(m01[2]);
      d02 <= DW'(m02[0]) + DW'(m02[1]) + DW'(m02[2]);
      d11 <= DW'(m11[0]) + DW'(m11[1]) + DW'(m11[2]);
      d12 <= DW'(m12[0]) + DW'(m12[1]) + DW'(m12[2]);
    end
  end

endmodule

### hdl/ptt_wide_mul.sv
// Two-stage signed multiplier: four half-width partial products, then their sum.
// Standalone; instantiated once for each product of dot products.
module ptt_wide_mul #(
  parameter int DW = 36
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [DW-1:0]    a,
  input  logic signed [DW-1:0]    b,
  output logic signed [2*DW-1:0]  p
);
  localparam int H  = DW / 2;
  localparam int HI = DW - H;
  localparam int PW = 2 * DW;
  localparam int XW = HI + H + 1;

  logic signed [HI-1:0]   a_hi, b_hi;
  logic signed [H:0]      a_lo, b_lo;
  logic signed [2*HI-1:0] pp_hh;
  logic signed [XW-1:0]   pp_hl, pp_lh;
  logic [2*H-1:0]         pp_ll;
  logic signed [PW-1:0]   t_hh, t_hl, t_lh, t_ll;

  // Low halves are unsigned; a zero on top keeps them positive in signed products
  assign a_hi = a[DW-1:H];
  assign b_hi = b[DW-1:H];
  assign a_lo = $signed({1'b0, a[H-1:0]});
  assign b_lo = $signed({1'b0, b[H-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= (2*HI)'(a_hi) * (2*HI)'(b_hi);
      pp_hl <= XW'(a_hi) * XW'(b_lo);
      pp_lh <= XW'(a_lo) * XW'(b_hi);
      pp_ll <= a[H-1:0] * b[H-1:0];
    end
  end

  assign t_hh = {pp_hh, {(2*H){1'b0}}};
  assign t_hl = {{(PW-XW-H){pp_hl[XW-1]}}, pp_hl, {H{1'b0}}};
  assign t_lh = {{(PW-XW-H){pp_lh[XW-1]}}, pp_lh, {H{1'b0}}};
  assign t_ll = {{(PW-2*H){1'b0}}, pp_ll};

  always_ff @(posedge clk) begin
    if (en) begin
      p <= t_hh + t_hl + t_lh + t_ll;
    end
  end

endmodule

### hdl/point_in_triangle_test.sv
// Top level of the barycentric point-in-triangle test: valid pipeline, final stages.
// Depends on ptt_pkg, ptt_cfg_regs, ptt_dot_front and ptt_wide_mul.
//
//   channel  | handshake                       | payload
//   ---------+---------------------------------+------------------------------
//   point    | point_valid / point_stall       | point_x, point_y, point_z
//   result   | res_valid / res_stall           | inside_res, degenerate
//   config   | cfg_we                          | cfg_index, cfg_data
//
// One query enters per cycle unless a held result stalls the pipeline.
// The six stages are: edge vectors, dot products, partial products of the
// wide multipliers, their sums, denominator and numerators, final compare.
// Reset clears the vertex registers and all stage valid bits.
// A stalled result holds the whole pipeline; point_stall follows it directly.
module point_in_triangle_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [3*COORD_WIDTH-1:0]       cfg_data,
  input  logic                           point_valid,
  output logic                           point_stall,
  input  logic signed [COORD_WIDTH-1:0]  point_x,
  input  logic signed [COORD_WIDTH-1:0]  point_y,
  input  logic signed [COORD_WIDTH-1:0]  point_z,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           inside_res,
  output logic                           degenerate
);
  import ptt_pkg::*;

  localparam int DW     = 2 * (COORD_WIDTH + 1) + 2;
  localparam int PW     = 2 * DW;
  localparam int SW     = PW + 2;
  localparam int NSTAGE = 6;

  logic [3*COORD_WIDTH-1:0] vertex_a, vertex_b, vertex_c;
  logic signed [DW-1:0]     d00, d01, d02, d11, d12;
  logic signed [PW-1:0]     p00_11, p01_01, p11_02, p01_12, p00_12, p01_02;
  logic signed [SW-1:0]     denom, nu, nv;
  logic signed [SW:0]       slack;
  logic [NSTAGE-1:0]        stage_valid;
  logic                     en;

  // Advance everything unless a finished result is being held
  assign en          = !stage_valid[NSTAGE-1] || !res_stall;
  assign point_stall = !en;
  assign res_valid   = stage_valid[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (en) begin
      stage_valid <= {stage_valid[NSTAGE-2:0], point_valid};
    end
  end

  ptt_cfg_regs #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vertex_c (vertex_c)
  );

  ptt_dot_front #(.COORD_WIDTH(COORD_WIDTH), .DW(DW)) u_front (
    .clk     (clk),
    .en      (en),
    .vertex_a(vertex_a),
    .vertex_b(vertex_b),
    .vertex_c(vertex_c),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z),
    .d00     (d00),
    .d01     (d01),
    .d02     (d02),
    .d11     (d11),
    .d12     (d12)
  );

  ptt_wide_mul #(.DW(DW)) u_mul_00_11 (.clk(clk), .en(en), .a(d00), .b(d11), .p(p00_11));
  ptt_wide_mul #(.DW(DW)) u_mul_01_01 (.clk(clk), .en(en), .a(d01), .b(d01), .p(p01_01));
  ptt_wide_mul #(.DW(DW)) u_mul_11_02 (.clk(clk), .en(en), .a(d11), .b(d02), .p(p11_02));
  ptt_wide_mul #(.DW(DW)) u_mul_01_12 (.clk(clk), .en(en), .a(d01), .b(d12), .p(p01_12));
  ptt_wide_mul #(.DW(DW)) u_mul_00_12 (.clk(clk), .en(en), .a(d00), .b(d12), .p(p00_12));
  ptt_wide_mul #(.DW(DW)) u_mul_01_02 (.clk(clk), .en(en), .a(d01), .b(d02), .p(p01_02));

  always_ff @(posedge clk) begin
    if (en) begin
      denom <= SW'(p00_11) - SW'(p01_01);
      nu    <= SW'(p11_02) - SW'(p01_12);
      nv    <= SW'(p00_12) - SW'(p01_02);
    end
  end

  // Inside when nu and nv are non-negative and nu + nv - denom is negative, that is u, v >= 0 and u + v < 1
  assign slack = (SW+1)'(nu) + (SW+1)'(nv) - (SW+1)'(denom);

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= (denom == '0);
      inside_res <= (denom != '0) && !nu[SW-1] && !nv[SW-1] && slack[SW];
    end
  end

endmodule
